[design/pidc_pkg.sv]
package pidc_pkg;

    // Default width of the integral accumulator.
    localparam int INTEGRAL_BITS_DEF = 40;

    // Fixed field widths.
    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DT_FRAC = 12;
    localparam int DERIV_W = DIFF_W + DT_FRAC;

    // Shared multiplier: unsigned 16-bit factor against a signed 33-bit factor.
    localparam int MUL_A_W = DATA_W + 1;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // The integral is split into two 32-bit halves of a 64-bit word for the multiplier.
    localparam int EXT_W       = 64;
    localparam int HALF_W      = EXT_W / 2;
    localparam int GAIN_SHIFT  = 8;
    localparam int INTEG_SHIFT = 20;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_PROP  = 3'd0,
        REG_GAIN_INTEG = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_OUT_LOWER  = 3'd3,
        REG_OUT_UPPER  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } t_clamp;

    typedef enum logic [2:0] {
        MUL_ERR_DT,
        MUL_PROP,
        MUL_INT_HI,
        MUL_INT_LO,
        MUL_DERIV
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_PROP,
        ACC_INT_HI,
        ACC_INT_LO,
        ACC_DERIV
    } t_acc_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ED,
        ST_INTEG,
        ST_MUL_IHI,
        ST_MUL_ILO,
        ST_ACC_ILO,
        ST_WAIT_DIV,
        ST_ACC_D,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0]        gain_prop;
        logic [DATA_W-1:0]        gain_integ;
        logic [DATA_W-1:0]        gain_deriv;
        logic signed [DATA_W-1:0] out_lower;
        logic signed [DATA_W-1:0] out_upper;
    } t_cfg;

    typedef struct packed {
        logic     load;
        logic     integ_upd;
        logic     div_start;
        t_mul_sel mul_sel;
        t_acc_sel acc_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic dt_zero;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

[design/pidc_in_if.sv]
interface pidc_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic [15:0]        dt;

    modport source (output valid, func, measured, target, dt, input ready);
    modport sink   (input valid, func, measured, target, dt, output ready);
endinterface

[design/pidc_out_if.sv]
interface pidc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic [1:0]         clamp_state;
    logic               dt_zero;

    modport source (output valid, drive, clamp_state, dt_zero, input ready);
    modport sink   (input valid, drive, clamp_state, dt_zero, output ready);
endinterface

[design/pidc_div.sv]
module pidc_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pidc_pkg::DIFF_W-1:0]    i_diff,
    input  logic [pidc_pkg::DATA_W-1:0]           i_den,
    output logic                                  o_busy,
    output logic signed [pidc_pkg::DERIV_W-1:0]   o_quot
);
    import pidc_pkg::*;

    // Sign and magnitude restoring division, one quotient bit per cycle.
    localparam int MAG_W = DIFF_W - 1;
    localparam int NUM_W = MAG_W + DT_FRAC;
    localparam int CNT_W = $clog2(NUM_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;
    logic [DATA_W-1:0]   r_den;
    logic [DATA_W-1:0]   r_rem;
    logic [NUM_W-1:0]    r_quo;

    logic [MAG_W-1:0]    diff_mag;
    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     trial_sub;
    logic                fits;
    logic [DERIV_W-1:0]  quo_ext;

    always_comb begin
        diff_mag  = i_diff[DIFF_W-1] ? MAG_W'(-i_diff) : MAG_W'(i_diff);
        trial     = {r_rem, r_quo[NUM_W-1]};
        trial_sub = trial - {1'b0, r_den};
        fits      = trial >= {1'b0, r_den};
        quo_ext   = DERIV_W'(r_quo);
        o_quot    = r_neg ? -$signed(quo_ext) : $signed(quo_ext);
        o_busy    = r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_diff[DIFF_W-1];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= {diff_mag, {DT_FRAC{1'b0}}};
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

endmodule

[design/pidc_dp.sv]
module pidc_dp #(
    parameter int INTEGRAL_BITS = pidc_pkg::INTEGRAL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pidc_pkg::t_dp_cmd                 i_cmd,
    output pidc_pkg::t_dp_sts                 o_sts,
    input  pidc_pkg::t_cfg                    i_cfg,
    input  logic                              i_func,
    input  logic signed [pidc_pkg::DATA_W-1:0] i_measured,
    input  logic signed [pidc_pkg::DATA_W-1:0] i_target,
    input  logic [pidc_pkg::DATA_W-1:0]       i_dt,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [pidc_pkg::DATA_W-1:0] o_drive,
    output logic [1:0]                        o_clamp_state,
    output logic                              o_dt_zero
);
    import pidc_pkg::*;

    localparam int IB    = INTEGRAL_BITS;
    localparam int SAT_W = ((IB > MUL_B_W) ? IB : MUL_B_W) + 1;
    localparam int SUM_W = ((IB > 42) ? IB - 4 : 38) + 2;

    localparam logic signed [SAT_W-1:0] IMAX = {{(SAT_W - IB + 1){1'b0}}, {(IB - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] IMIN = ~IMAX;

    logic                      r_func;
    logic signed [ERR_W-1:0]   r_err;
    logic [DATA_W-1:0]         r_dt;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [IB-1:0]      r_integ;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;
    t_clamp                    r_clamp;
    logic                      r_dt_zero;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [IB-1:0]      n_integ;
    logic signed [SUM_W-1:0]   n_sum;
    logic                      dt_zero;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [EXT_W-1:0]   integ_ext;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [DERIV_W-1:0] div_quot;
    logic signed [DERIV_W-1:0] deriv;
    logic                      div_busy;
    logic signed [SAT_W-1:0]   sat_sum;
    logic signed [SUM_W-1:0]   lim_lo;
    logic signed [SUM_W-1:0]   lim_hi;
    logic signed [DATA_W-1:0]  clamp_drive;
    t_clamp                    clamp_code;

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_diff  (diff),
        .i_den   (r_dt),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_err     = ERR_W'(i_target) - ERR_W'(i_measured);
        dt_zero   = (r_dt == '0);
        diff      = DIFF_W'(r_err) - DIFF_W'(r_last_err);
        integ_ext = EXT_W'(r_integ);
        deriv     = dt_zero ? '0 : div_quot;

        o_sts.dt_zero  = dt_zero;
        o_sts.div_busy = div_busy;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR_DT: begin
                mul_a = {1'b0, r_dt};
                mul_b = MUL_B_W'(r_err);
            end
            MUL_PROP: begin
                mul_a = {1'b0, i_cfg.gain_prop};
                mul_b = MUL_B_W'(r_err);
            end
            MUL_INT_HI: begin
                mul_a = {1'b0, i_cfg.gain_integ};
                mul_b = MUL_B_W'($signed(integ_ext[EXT_W-1:HALF_W]));
            end
            MUL_INT_LO: begin
                mul_a = {1'b0, i_cfg.gain_integ};
                mul_b = {1'b0, integ_ext[HALF_W-1:0]};
            end
            MUL_DERIV: begin
                mul_a = {1'b0, i_cfg.gain_deriv};
                mul_b = MUL_B_W'(deriv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_full = mul_a * mul_b;
    end

    // Saturating integral update; the error times dt product sits in the low bits of r_prod.
    always_comb begin
        sat_sum = SAT_W'(r_integ) + SAT_W'($signed(r_prod[MUL_B_W-1:0]));
        if (sat_sum > IMAX) begin
            n_integ = IMAX[IB-1:0];
        end else if (sat_sum < IMIN) begin
            n_integ = IMIN[IB-1:0];
        end else begin
            n_integ = sat_sum[IB-1:0];
        end
    end

    // Each gain term is floored on its own before it joins the sum.
    always_comb begin
        case (i_cmd.acc_sel)
            ACC_PROP:   n_sum = SUM_W'(r_prod >>> GAIN_SHIFT);
            ACC_INT_HI: n_sum = r_sum + (SUM_W'(r_prod) <<< (HALF_W - INTEG_SHIFT));
            ACC_INT_LO: n_sum = r_sum + SUM_W'({1'b0, r_prod[DATA_W+HALF_W-1:INTEG_SHIFT]});
            ACC_DERIV:  n_sum = r_sum + SUM_W'(r_prod >>> GAIN_SHIFT);
            default:    n_sum = r_sum;
        endcase
    end

    // Clamp, with the upper limit tested first; a clear item gives a zero drive and no clamp.
    always_comb begin
        lim_lo = SUM_W'(i_cfg.out_lower);
        lim_hi = SUM_W'(i_cfg.out_upper);
        if (r_func) begin
            clamp_drive = '0;
            clamp_code  = CLAMP_NONE;
        end else if (r_sum > lim_hi) begin
            clamp_drive = i_cfg.out_upper;
            clamp_code  = CLAMP_HIGH;
        end else if (r_sum < lim_lo) begin
            clamp_drive = i_cfg.out_lower;
            clamp_code  = CLAMP_LOW;
        end else begin
            clamp_drive = r_sum[DATA_W-1:0];
            clamp_code  = CLAMP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_func) begin
                r_integ    <= '0;
                r_last_err <= '0;
            end else if (i_cmd.integ_upd) begin
                r_integ    <= n_integ;
                r_last_err <= r_err;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_err  <= n_err;
            r_dt   <= i_dt;
        end
        r_prod <= prod_full;
        r_sum  <= n_sum;
        if (i_cmd.out_load) begin
            r_drive   <= clamp_drive;
            r_clamp   <= clamp_code;
            r_dt_zero <= !r_func && dt_zero;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_clamp_state = r_clamp;
    assign o_dt_zero     = r_dt_zero;

endmodule

[design/pidc_ctrl.sv]
module pidc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_func,
    input  pidc_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output pidc_pkg::t_dp_cmd o_cmd
);
    import pidc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_func ? ST_FINISH : ST_MUL_ED;
                end
            end
            ST_MUL_ED:   n_state = ST_INTEG;
            ST_INTEG:    n_state = ST_MUL_IHI;
            ST_MUL_IHI:  n_state = ST_MUL_ILO;
            ST_MUL_ILO:  n_state = ST_ACC_ILO;
            ST_ACC_ILO:  n_state = ST_WAIT_DIV;
            ST_WAIT_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_ACC_D;
                end
            end
            ST_ACC_D:    n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.integ_upd = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.mul_sel   = MUL_ERR_DT;
        o_cmd.acc_sel   = ACC_NONE;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL_ED: begin
                o_cmd.mul_sel = MUL_ERR_DT;
            end
            ST_INTEG: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.div_start = !i_sts.dt_zero;
                o_cmd.mul_sel   = MUL_PROP;
            end
            ST_MUL_IHI: begin
                o_cmd.acc_sel = ACC_PROP;
                o_cmd.mul_sel = MUL_INT_HI;
            end
            ST_MUL_ILO: begin
                o_cmd.acc_sel = ACC_INT_HI;
                o_cmd.mul_sel = MUL_INT_LO;
            end
            ST_ACC_ILO: begin
                o_cmd.acc_sel = ACC_INT_LO;
            end
            ST_WAIT_DIV: begin
                o_cmd.mul_sel = MUL_DERIV;
            end
            ST_ACC_D: begin
                o_cmd.acc_sel = ACC_DERIV;
            end
            ST_FINISH: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[design/pid_controller_clamped.sv]
// Channel   Direction  Carries
// i_in      sink       func, measured, target, dt (valid/ready transfer)
// o_out     source     drive, clamp_state, dt_zero (valid/ready transfer)
// APB       slave      gain_prop, gain_integ, gain_deriv, out_lower, out_upper at 4*i
//
// A control step runs from its transfer into i_in through the bit-serial
// derivative divider to its result in the output register; a zero dt skips
// the divider and a clear item goes straight to the result. i_in is ready
// again once the result is loaded. Reset clears the integral, previous error,
// gains and control state, and sets the output limits to the full range. A stalled
// o_out holds its result; the next item is worked on and then waits at its last step.
module pid_controller_clamped #(
    parameter int INTEGRAL_BITS = pidc_pkg::INTEGRAL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pidc_pkg::PADDR_W-1:0]     paddr,
    input  logic [pidc_pkg::PDATA_W-1:0]     pwdata,
    output logic [pidc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    pidc_in_if.sink                          i_in,
    pidc_out_if.source                       o_out
);
    import pidc_pkg::*;

    // Configuration registers, read directly by the datapath with no shadow copy;
    // writes must arrive only while the block is idle, which it does not enforce.
    t_cfg           r_cfg;
    logic           cfg_wr;
    t_reg_idx       reg_idx;

    t_dp_cmd        dp_cmd;
    t_dp_sts        dp_sts;
    logic           in_ready;
    logic           out_valid;
    logic signed [DATA_W-1:0] out_drive;
    logic [1:0]     out_clamp;
    logic           out_dt_zero;

    // Register index is the word address; the byte offset within a word is ignored.
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= '0;
            r_cfg.gain_integ <= '0;
            r_cfg.gain_deriv <= '0;
            r_cfg.out_lower  <= {1'b1, {(DATA_W - 1){1'b0}}};
            r_cfg.out_upper  <= {1'b0, {(DATA_W - 1){1'b1}}};
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GAIN_PROP:  r_cfg.gain_prop  <= pwdata[DATA_W-1:0];
                REG_GAIN_INTEG: r_cfg.gain_integ <= pwdata[DATA_W-1:0];
                REG_GAIN_DERIV: r_cfg.gain_deriv <= pwdata[DATA_W-1:0];
                REG_OUT_LOWER:  r_cfg.out_lower  <= $signed(pwdata[DATA_W-1:0]);
                REG_OUT_UPPER:  r_cfg.out_upper  <= $signed(pwdata[DATA_W-1:0]);
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Read-back: gains zero-extended, limits sign-extended.
    always_comb begin
        unique case (reg_idx)
            REG_GAIN_PROP:  prdata = PDATA_W'(r_cfg.gain_prop);
            REG_GAIN_INTEG: prdata = PDATA_W'(r_cfg.gain_integ);
            REG_GAIN_DERIV: prdata = PDATA_W'(r_cfg.gain_deriv);
            REG_OUT_LOWER:  prdata = PDATA_W'(r_cfg.out_lower);
            REG_OUT_UPPER:  prdata = PDATA_W'(r_cfg.out_upper);
            default:        prdata = '0;
        endcase
    end

    // The controller sequences the shared multiplier, the accumulator and
    // the divider; it only sees the datapath through the command and status
    // structures.
    pidc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_sts      (dp_sts),
        .o_in_ready (in_ready),
        .o_cmd      (dp_cmd)
    );

    pidc_dp #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg         (r_cfg),
        .i_func        (i_in.func),
        .i_measured    (i_in.measured),
        .i_target      (i_in.target),
        .i_dt          (i_in.dt),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .o_drive       (out_drive),
        .o_clamp_state (out_clamp),
        .o_dt_zero     (out_dt_zero)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.drive       = out_drive;
    assign o_out.clamp_state = out_clamp;
    assign o_out.dt_zero     = out_dt_zero;

endmodule

[verif/tb_pid_controller_clamped.sv]
// Function codes carried by one input transfer.
localparam bit FUNC_STEP  = 1'b0;
localparam bit FUNC_CLEAR = 1'b1;

typedef struct packed {
    logic signed [15:0] drive;
    pidc_pkg::t_clamp   clamp;
    logic               dt_zero;
} t_drive_result;

// Tracks the controller's own state, predicts each drive value and checks
// the results in order.
class pid_drive_tracker;
    int                 integ_bits;
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        kd;
    logic signed [15:0] lower;
    logic signed [15:0] upper;
    longint             integ;
    longint             last_err;
    t_drive_result      pending_drive[$];
    int                 errors;
    int                 n_checked;

    function new(int bits);
        integ_bits = bits;
        kp         = '0;
        ki         = '0;
        kd         = '0;
        lower      = 16'sh8000;
        upper      = 16'sh7FFF;
        integ      = 0;
        last_err   = 0;
        errors     = 0;
        n_checked  = 0;
    endfunction

    function void set_reg(pidc_pkg::t_reg_idx idx, logic [15:0] value);
        case (idx)
            pidc_pkg::REG_GAIN_PROP:  kp    = value;
            pidc_pkg::REG_GAIN_INTEG: ki    = value;
            pidc_pkg::REG_GAIN_DERIV: kd    = value;
            pidc_pkg::REG_OUT_LOWER:  lower = value;
            pidc_pkg::REG_OUT_UPPER:  upper = value;
            default: ;
        endcase
    endfunction

    // Called for every accepted input transfer.
    function void note_step(bit fn, logic signed [15:0] meas, logic signed [15:0] tgt,
                            logic [15:0] dt);
        t_drive_result res;
        longint        err;
        longint        prod;
        longint        imax;
        longint        imin;
        longint        span;
        longint        slope;
        longint        g_p;
        longint        g_i;
        longint        g_d;
        longint        p_term;
        longint        i_term;
        longint        d_term;
        longint        total;
        res.drive   = '0;
        res.clamp   = pidc_pkg::CLAMP_NONE;
        res.dt_zero = 1'b0;
        if (fn == FUNC_CLEAR) begin
            integ    = 0;
            last_err = 0;
            pending_drive.push_back(res);
            return;
        end
        err  = longint'(tgt) - longint'(meas);
        span = longint'(dt);
        prod = err * span;
        imax = (longint'(1) << (integ_bits - 1)) - 1;
        imin = -imax - 1;
        if (prod > 0 && integ > imax - prod) begin
            integ = imax;
        end else if (prod < 0 && integ < imin - prod) begin
            integ = imin;
        end else begin
            integ = integ + prod;
        end
        if (dt == 0) begin
            slope       = 0;
            res.dt_zero = 1'b1;
        end else begin
            slope = ((err - last_err) * 4096) / span;
        end
        g_p    = longint'(kp);
        g_i    = longint'(ki);
        g_d    = longint'(kd);
        p_term = (g_p * err) >>> 8;
        i_term = g_i * (integ >>> 20) + ((g_i * (integ & longint'(20'hFFFFF))) >>> 20);
        d_term = (g_d * slope) >>> 8;
        total  = p_term + i_term + d_term;
        if (total > longint'(upper)) begin
            res.drive = upper;
            res.clamp = pidc_pkg::CLAMP_HIGH;
        end else if (total < longint'(lower)) begin
            res.drive = lower;
            res.clamp = pidc_pkg::CLAMP_LOW;
        end else begin
            res.drive = total[15:0];
        end
        last_err = err;
        pending_drive.push_back(res);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch at result %0d: %s", n_checked, msg);
    endtask

    task check_drive(logic signed [15:0] drive, logic [1:0] cs, logic dz);
        t_drive_result want;
        n_checked++;
        if (pending_drive.size() == 0) begin
            report_mismatch("result transfer with no step outstanding");
            return;
        end
        want = pending_drive.pop_front();
        if (drive !== want.drive) begin
            report_mismatch($sformatf("drive %0d, expected %0d", drive, want.drive));
        end
        if (cs !== want.clamp) begin
            report_mismatch($sformatf("clamp_state %0d, expected %0d", cs, want.clamp));
        end
        if (dz !== want.dt_zero) begin
            report_mismatch($sformatf("dt_zero %0b, expected %0b", dz, want.dt_zero));
        end
    endtask
endclass

module tb_pid_controller_clamped;
    import pidc_pkg::*;

    localparam int INTEG_W     = INTEGRAL_BITS_DEF;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 123;
    // The long hold on the result side starts once this many results are in.
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 300;
    // Longest correct quiet spell is the long hold plus one step; the watchdog
    // allows several times that.
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef enum {MODE_MIXED, MODE_WIND_UP, MODE_WIND_DOWN, MODE_FINE} t_stim_mode;

    // Two phases of winding up and three of winding down drive the integral
    // into positive and then negative saturation, since no clear is sent there.
    t_stim_mode phase_plan [NUM_PHASES] = '{MODE_MIXED, MODE_MIXED, MODE_WIND_UP,
                                            MODE_WIND_UP, MODE_WIND_DOWN, MODE_WIND_DOWN,
                                            MODE_WIND_DOWN, MODE_FINE, MODE_MIXED, MODE_FINE};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pidc_in_if  in_ch ();
    pidc_out_if out_ch ();

    pid_drive_tracker drive_model;

    bit          burst_mode  = 1'b0;
    bit          hold_done   = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;

    pid_controller_clamped #(
        .INTEGRAL_BITS (INTEG_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Idle spells for both sides: mostly none or short, now and then long.
    // In a burst phase no idle spell is picked for either side.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_mode) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // A value near the base, kept inside the signed 16-bit range.
    function automatic logic signed [15:0] near_value(logic signed [15:0] base, int spread);
        int     offset;
        longint v;
        offset = int'($urandom_range(0, 2 * spread)) - spread;
        v      = longint'(base) + longint'(offset);
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_gain();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return 16'h0000;
        end
        if (roll < 25) begin
            return 16'hFFFF;
        end
        if (roll < 55) begin
            return 16'($urandom_range(0, 16'h0200));
        end
        return 16'($urandom);
    endfunction

    // Result side: ready is changed on the falling edge. Once, part way
    // through the run, it is held low for a long stretch while the input side
    // keeps offering, so the block fills and has to refuse input transfers.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && drive_model.n_checked >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                if ($urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Every result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            drive_model.check_drive(out_ch.drive, out_ch.clamp_state, out_ch.dt_zero);
        end
    end

    // The watchdog counts cycles in which no transfer happens on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // One APB write: setup phase, then access phase; the register takes the
    // value at the rising edge that ends the access phase.
    task automatic write_reg(t_reg_idx idx, logic [15:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        if (idx == REG_OUT_LOWER || idx == REG_OUT_UPPER) begin
            pwdata = {{16{value[15]}}, value};
        end else begin
            pwdata = {16'h0000, value};
        end
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        drive_model.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stops offering input and waits until every predicted result has been
    // taken. Each item yields exactly one result, so the block is then idle.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (drive_model.pending_drive.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers are only written once the block has drained.
    task automatic apply_config(logic [15:0] g_p, logic [15:0] g_i, logic [15:0] g_d,
                                logic signed [15:0] lo, logic signed [15:0] hi);
        drain();
        write_reg(REG_GAIN_PROP, g_p);
        write_reg(REG_GAIN_INTEG, g_i);
        write_reg(REG_GAIN_DERIV, g_d);
        write_reg(REG_OUT_LOWER, lo);
        write_reg(REG_OUT_UPPER, hi);
    endtask

    task automatic configure_random(t_stim_mode mode);
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        int unsigned        roll;
        a    = 16'($urandom);
        b    = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            lo = 16'sh8000;
            hi = 16'sh7FFF;
        end else if (roll < 70) begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end else if (roll < 85) begin
            // Crossed limits: the upper test wins.
            lo = (a < b) ? b : a;
            hi = (a < b) ? a : b;
        end else begin
            lo = a;
            hi = a;
        end
        if (mode == MODE_FINE) begin
            apply_config(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                         16'($urandom_range(0, 512)), lo, hi);
        end else begin
            apply_config(pick_gain(), pick_gain(), pick_gain(), lo, hi);
        end
    endtask

    // Offers one item after a random gap and waits for its transfer; valid
    // stays high until the next falling edge, where it is either lowered or
    // carries the next item.
    task automatic send_item(bit fn, logic signed [15:0] meas, logic signed [15:0] tgt,
                             logic [15:0] span);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.func     = fn;
        in_ch.measured = meas;
        in_ch.target   = tgt;
        in_ch.dt       = span;
        do @(posedge i_clk); while (!in_ch.ready);
        drive_model.note_step(fn, meas, tgt, span);
    endtask

    task automatic send_random(t_stim_mode mode);
        int unsigned        roll;
        int unsigned        pick;
        bit                 fn;
        logic signed [15:0] meas;
        logic signed [15:0] tgt;
        logic [15:0]        span;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        fn   = FUNC_STEP;
        meas = 16'($urandom);
        tgt  = 16'($urandom);
        span = 16'($urandom);
        case (mode)
            MODE_MIXED: begin
                if (roll < 6) begin
                    fn = FUNC_CLEAR;
                end
                if (roll >= 50) begin
                    tgt = near_value(meas, 2000);
                end
                if (pick < 10) begin
                    span = 16'h0000;
                end else if (pick < 15) begin
                    span = 16'h0001;
                end else if (pick < 20) begin
                    span = 16'hFFFF;
                end else if (pick < 50) begin
                    span = 16'($urandom_range(1, 16'h0200));
                end
            end
            MODE_WIND_UP, MODE_WIND_DOWN: begin
                // A few items are pure noise; the rest push the error hard in
                // one direction, with long timesteps or now and then a zero one.
                if (roll >= 8) begin
                    meas = 16'(-32768 + int'($urandom_range(0, 4768)));
                    tgt  = 16'(28000 + int'($urandom_range(0, 4767)));
                    if (mode == MODE_WIND_DOWN) begin
                        {meas, tgt} = {tgt, meas};
                    end
                    span = (pick < 10) ? 16'h0000 : 16'($urandom_range(52000, 65535));
                end
            end
            default: begin
                if (roll < 3) begin
                    fn = FUNC_CLEAR;
                end
                tgt  = near_value(meas, 200);
                span = (pick < 8) ? 16'h0000 : 16'($urandom_range(1, 16'h0400));
            end
        endcase
        send_item(fn, meas, tgt, span);
    endtask

    initial begin
        drive_model    = new(INTEG_W);
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_STEP;
        in_ch.measured = '0;
        in_ch.target   = '0;
        in_ch.dt       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, unity proportional and derivative gains first.
        apply_config(16'h0100, 16'h0040, 16'h0100, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(FUNC_STEP, 16'sd0, 16'sd0, 16'h1000);
        // Largest positive and then largest negative error, longest timestep.
        send_item(FUNC_STEP, 16'sh8000, 16'sh7FFF, 16'hFFFF);
        send_item(FUNC_STEP, 16'sh7FFF, 16'sh8000, 16'hFFFF);
        // Zero timestep leaves the integral alone and flags the derivative.
        send_item(FUNC_STEP, 16'sd100, 16'sd200, 16'h0000);
        // Shortest timestep gives the steepest derivative.
        send_item(FUNC_STEP, 16'sd0, 16'sh7FFF, 16'h0001);
        send_item(FUNC_STEP, 16'sh8000, 16'sh7FFF, 16'h0001);
        send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(FUNC_STEP, 16'sd1000, 16'sd1010, 16'h0100);
        send_item(FUNC_STEP, 16'sd10, -16'sd5, 16'h0800);
        send_item(FUNC_STEP, 16'sh5555, 16'shAAAA, 16'h5555);
        send_item(FUNC_STEP, 16'shAAAA, 16'sh5555, 16'hAAAA);

        // Crossed limits: a sum above the upper limit is caught first.
        apply_config(16'h0100, 16'h0000, 16'h0000, 16'sd100, -16'sd100);
        send_item(FUNC_STEP, 16'sd0, 16'sd0, 16'h1000);
        send_item(FUNC_STEP, 16'sd300, 16'sd0, 16'h1000);
        send_item(FUNC_STEP, 16'sd0, 16'sd300, 16'h0000);

        // Largest gains with both limits equal.
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd5, -16'sd5);
        send_item(FUNC_STEP, 16'sd0, 16'sd0, 16'h1000);
        send_item(FUNC_STEP, 16'sh8000, 16'sh7FFF, 16'hFFFF);
        send_item(FUNC_STEP, 16'sh7FFF, 16'sh8000, 16'h0000);
        send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(FUNC_STEP, 16'sd0, 16'sd0, 16'h0000);

        // Random phases. State carries over from phase to phase, so the
        // windup phases build on each other.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            burst_mode = 1'b0;
            case (ph)
                0: apply_config(16'h0000, 16'h0000, 16'h0000, 16'sh8000, 16'sh7FFF);
                1: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh7FFF);
                6: apply_config(pick_gain(), pick_gain(), pick_gain(), 16'sh7FFF, 16'sh8000);
                default: configure_random(phase_plan[ph]);
            endcase
            burst_mode = (ph % 3 == 2);
            repeat (PHASE_ITEMS) send_random(phase_plan[ph]);
        end

        burst_mode = 1'b0;
        drain();
        // Let the block sit for longer than one step so that a stray result
        // would still be caught.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (drive_model.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
